/* hdl/dtes_pkg.sv */
// Shared widths, constants and the month table for the date to epoch-seconds converter.
package dtes_pkg;

  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;
  localparam int EpochW  = 31;

  localparam int YearDaysW = 21;   // whole-year days, up to year 4095
  localparam int DoyW      = 10;   // month offset plus day of month
  localparam int DaysW     = 22;   // signed day count
  localparam int TodW      = 17;   // seconds within the day, any field value
  localparam int ProdW     = 40;   // signed day count times seconds per day
  localparam int TotalW    = 41;

  localparam logic [YearW-1:0]   BaseYear     = 12'd1990;
  localparam logic [8:0]         LeapsBefore  = 9'd482;    // leap years in 1..1989
  localparam logic [8:0]         DaysPerYear  = 9'd365;
  localparam logic [10:0]        Recip100     = 11'd1311;  // 2^17 / 100, rounded up
  localparam int                 Recip100Sh   = 17;
  localparam logic [6:0]         Hundred      = 7'd100;
  localparam logic [11:0]        SecsHour     = 12'd3600;
  localparam logic [5:0]         SecsMinute   = 6'd60;
  localparam logic signed [17:0] SecsDay      = 18'sd86400;
  localparam logic [EpochW-1:0]  EpochMax     = {EpochW{1'b1}};

  typedef logic [YearW-1:0]   year_t;
  typedef logic [EpochW-1:0]  epoch_t;

  // days before the first of each month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] mi);
    logic [8:0] d;
    unique case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

  // floor(n / 100) for any 12-bit n
  function automatic logic [5:0] div100(input logic [YearW-1:0] n);
    logic [YearW+10:0] p;
    p = n * Recip100;
    return p[YearW+10:Recip100Sh];
  endfunction

endpackage

/* hdl/dtes_if.sv */
// Handshake channels for timestamp items in and epoch-seconds items out.
interface dtes_in_if;
  import dtes_pkg::*;
  logic               valid;
  logic               ready;
  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [DayW-1:0]    day;
  logic [HourW-1:0]   hour;
  logic [MinuteW-1:0] minute;
  logic [SecondW-1:0] second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface dtes_out_if;
  import dtes_pkg::*;
  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink   (input valid, epoch_seconds, output ready);
endinterface

/* hdl/date_time_to_epoch_seconds_top.sv */
// Date and time of day to seconds since 1990-01-01, four-stage pipeline.
// An accepted item moves through the stage 1, stage 2, stage 3 and output registers in order.
// Throughput: one item per cycle while dout.ready holds; each stage advances when it is empty or the next one moves.
// Stages: divide by 100 and month table, day count and time of day, day multiply, sum and clamp.
// Reset clears the stage valid bits only; payload registers are not reset.
module date_time_to_epoch_seconds_top (
  input logic clk,
  input logic rst,
  dtes_in_if.sink    din,
  dtes_out_if.source dout
);
  import dtes_pkg::*;

  // stage 1
  logic                   v1;
  logic                   gt1;
  logic [YearW-1:0]       year1;
  logic [YearW-1:0]       ym1_1;
  logic [5:0]             qy1;
  logic [5:0]             qm1;
  logic [YearDaysW-2:0]   yd0_1;
  logic [DoyW-1:0]        doyb1;
  logic                   late1;
  logic [HourW-1:0]       hour1;
  logic [MinuteW-1:0]     minute1;
  logic [SecondW-1:0]     second1;
  // stage 2
  logic                   v2;
  logic signed [DaysW-1:0] days2;
  logic [TodW-1:0]        tod2;
  // stage 3
  logic                   v3;
  logic signed [ProdW-1:0] prod3;
  logic [TodW-1:0]        tod3;
  // output
  logic                   vout;
  epoch_t                 epoch;

  logic rdy1, rdy2, rdy3;

  assign rdy3      = !vout || dout.ready;
  assign rdy2      = !v3 || rdy3;
  assign rdy1      = !v2 || rdy2;
  assign din.ready = !v1 || rdy1;

  // stage 1 logic
  logic [3:0]           mi;
  logic [YearW-1:0]     ym1;
  logic [YearW-1:0]     ydiff;
  logic [YearDaysW-2:0] yd0_full;

  always_comb begin
    mi       = (din.month == 4'd0 || din.month > 4'd12) ? 4'd11 : din.month - 4'd1;
    ym1      = din.year - 12'd1;
    ydiff    = din.year - BaseYear;
    yd0_full = ydiff * DaysPerYear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (din.ready) begin
      v1 <= din.valid;
    end
    if (din.ready && din.valid) begin
      gt1     <= din.year > BaseYear;
      year1   <= din.year;
      ym1_1   <= ym1;
      qy1     <= div100(din.year);
      qm1     <= div100(ym1);
      yd0_1   <= yd0_full;
      doyb1   <= DoyW'(cum_days(mi)) + DoyW'(din.day);
      late1   <= mi >= 4'd2;
      hour1   <= din.hour;
      minute1 <= din.minute;
      second1 <= din.second;
    end
  end

  // stage 2 logic
  logic                 leap2;
  logic [12:0]          hund2;
  logic [YearDaysW-1:0] ydays2;
  logic [YearDaysW-1:0] dsum2;
  logic [TodW-1:0]      tod_n;

  always_comb begin
    hund2  = qy1 * Hundred;
    leap2  = (year1[1:0] == 2'b00) && ((hund2 != {1'b0, year1}) || (qy1[1:0] == 2'b00));
    ydays2 = '0;
    if (gt1) begin
      ydays2 = YearDaysW'(yd0_1) + YearDaysW'(ym1_1[YearW-1:2]) - YearDaysW'(qm1)
             + YearDaysW'(qm1[5:2]) - YearDaysW'(LeapsBefore);
    end
    dsum2 = ydays2 + YearDaysW'(doyb1) + YearDaysW'(leap2 && late1);
    tod_n = TodW'(hour1) * TodW'(SecsHour) + TodW'(minute1) * TodW'(SecsMinute)
          + TodW'(second1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy1) begin
      v2 <= v1;
    end
    if (rdy1 && v1) begin
      // day of month counts from one
      days2 <= $signed({1'b0, dsum2}) - 22'sd1;
      tod2  <= tod_n;
    end
  end

  // stage 3: day count times seconds per day
  logic signed [ProdW-1:0] prod_n;

  assign prod_n = days2 * SecsDay;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy2) begin
      v3 <= v2;
    end
    if (rdy2 && v2) begin
      prod3 <= prod_n;
      tod3  <= tod2;
    end
  end

  // stage 4: add time of day and clamp to the output range
  logic signed [TotalW-1:0] total;
  epoch_t                   clamped;

  always_comb begin
    total = TotalW'(prod3) + $signed({{(TotalW-TodW){1'b0}}, tod3});
    priority if (total < 0) begin
      clamped = '0;
    end else if (total > $signed({{(TotalW-EpochW){1'b0}}, EpochMax})) begin
      clamped = EpochMax;
    end else begin
      clamped = total[EpochW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (rdy3) begin
      vout <= v3;
    end
    if (rdy3 && v3) begin
      epoch <= clamped;
    end
  end

  assign dout.valid         = vout;
  assign dout.epoch_seconds = epoch;

`ifndef SYNTH
  a_enter: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> v1)
    else $error("accepted item did not reach stage 1");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    v3 && rdy3 |=> vout)
    else $error("stage 3 item lost on the way to the output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !rdy1 |=> v2 && $stable(days2) && $stable(tod2))
    else $error("stalled stage 2 item changed");

  a_div: assert property (@(posedge clk) disable iff (rst)
    v1 && gt1 |-> qm1 <= qy1 && qy1 <= qm1 + 6'd1)
    else $error("year divide by 100 inconsistent");

  a_days: assert property (@(posedge clk) disable iff (rst)
    v2 |-> days2 >= -22'sd1)
    else $error("day count below minus one");
`endif

endmodule

/* dv/date_time_to_epoch_seconds_top_tb.sv */
// Testbench for the date to epoch-seconds converter: directed table, random timestamps, scoreboard.
module date_time_to_epoch_seconds_top_tb;
  import dtes_pkg::*;

  localparam longint SecsPerYear = 31536000;
  localparam longint SecsPerDay  = 86400;
  localparam longint SecsPerHour = 3600;
  localparam longint SecsPerMin  = 60;
  localparam longint EpochYear   = 1990;
  localparam longint AllOnes     = 2147483647;
  localparam longint Predict     = -1;

  localparam int NumDir      = 25;
  localparam int NumRandom   = 1150;
  localparam int HoldStart   = 300;   // receiver cycle at which the long hold-off begins
  localparam int HoldLen     = 250;
  localparam int DrainCycles = 12;
  localparam int IdleLimit   = 2000;

  typedef struct packed {
    year_t              year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } stamp_t;

  typedef struct packed {
    logic   known;
    epoch_t value;
  } typed_t;

  typedef struct packed {
    stamp_t stamp;
    typed_t result;
  } row_t;

  typedef enum logic [1:0] {RxOpen, RxCoin, RxSparse, RxComb} rx_mode_e;

  // days before the first of each month, common year
  int month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic clk = 1'b0;
  logic rst;

  dtes_in_if  din ();
  dtes_out_if dout ();

  date_time_to_epoch_seconds_top dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  epoch_t epoch_q [$];
  typed_t typed_q [$];
  int     errors      = 0;
  int     idle_cycles = 0;
  row_t   dir_rows [NumDir];

  function automatic bit is_leap(longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // leap years in 1..n
  function automatic longint leaps_upto(longint n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic epoch_t epoch_of(stamp_t s);
    longint yr;
    longint doy;
    longint total;
    int     mi;
    yr    = longint'(s.year);
    total = 0;
    if (yr > EpochYear) begin
      total = (yr - EpochYear) * SecsPerYear
            + (leaps_upto(yr - 1) - leaps_upto(EpochYear - 1)) * SecsPerDay;
    end
    // out-of-range month counts as December
    mi  = (s.month == 0 || s.month > 12) ? 11 : int'(s.month) - 1;
    doy = longint'(month_start[mi]) + longint'(s.day) - 1;
    if (mi >= 2 && is_leap(yr)) doy = doy + 1;
    total = total + doy * SecsPerDay + longint'(s.hour) * SecsPerHour
          + longint'(s.minute) * SecsPerMin + longint'(s.second);
    if (total < 0) total = 0;
    if (total > AllOnes) total = AllOnes;
    return epoch_t'(total);
  endfunction

  function automatic row_t entry(int y, int mo, int d, int h, int mi, int s, longint v);
    row_t r;
    r.stamp.year   = year_t'(y);
    r.stamp.month  = MonthW'(mo);
    r.stamp.day    = DayW'(d);
    r.stamp.hour   = HourW'(h);
    r.stamp.minute = MinuteW'(mi);
    r.stamp.second = SecondW'(s);
    r.result.known = (v >= 0);
    r.result.value = epoch_t'(v);
    return r;
  endfunction

  // mostly plausible timestamps, with a share of raw field values
  function automatic stamp_t random_stamp();
    stamp_t s;
    int     pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)       s.year = year_t'($urandom_range(1950, 2057));
    else if (pick == 7) s.year = year_t'($urandom_range(1986, 1994));
    else if (pick == 8) s.year = year_t'($urandom_range(2054, 2070));
    else                s.year = year_t'($urandom_range(0, 4095));
    s.month  = ($urandom_range(0, 9) < 8) ? MonthW'($urandom_range(1, 12))
                                           : MonthW'($urandom_range(0, 15));
    s.day    = ($urandom_range(0, 19) == 0) ? '0 : DayW'($urandom_range(1, 31));
    s.hour   = ($urandom_range(0, 9) < 8) ? HourW'($urandom_range(0, 23))
                                           : HourW'($urandom_range(0, 31));
    s.minute = ($urandom_range(0, 9) < 8) ? MinuteW'($urandom_range(0, 59))
                                           : MinuteW'($urandom_range(0, 63));
    s.second = ($urandom_range(0, 9) < 8) ? SecondW'($urandom_range(0, 59))
                                           : SecondW'($urandom_range(0, 63));
    return s;
  endfunction

  int burst_left = 0;

  task automatic send(row_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        din.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    typed_q.push_back(r.result);
    din.year   <= r.stamp.year;
    din.month  <= r.stamp.month;
    din.day    <= r.stamp.day;
    din.hour   <= r.stamp.hour;
    din.minute <= r.stamp.minute;
    din.second <= r.stamp.second;
    din.valid  <= 1'b1;
    do @(posedge clk); while (!din.ready);
  endtask

  // scoreboard: predict on input accept, compare on output accept
  always @(posedge clk) begin : monitor
    stamp_t s;
    typed_t t;
    epoch_t want;
    bit     moved;
    if (!rst) begin
      moved = 1'b0;
      if (din.valid && din.ready) begin
        s = {din.year, din.month, din.day, din.hour, din.minute, din.second};
        t = typed_q.pop_front();
        epoch_q.push_back(t.known ? t.value : epoch_of(s));
        moved = 1'b1;
      end
      if (dout.valid && dout.ready) begin
        moved = 1'b1;
        if (epoch_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: epoch_seconds expected none, got %0d", $time, dout.epoch_seconds);
        end else begin
          want = epoch_q.pop_front();
          if (dout.epoch_seconds !== want) begin
            errors = errors + 1;
            $display("%0t: epoch_seconds expected %0d, got %0d",
                     $time, want, dout.epoch_seconds);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IdleLimit);
    $display("date_time_to_epoch_seconds_top_tb: done, errors");
    $finish;
  end

  initial begin : receiver
    int       cyc;
    rx_mode_e mode;
    logic     rdy;
    dout.ready <= 1'b0;
    cyc  = 0;
    mode = RxOpen;
    forever begin
      @(posedge clk);
      cyc = cyc + 1;
      if (cyc % 64 == 0) mode = rx_mode_e'($urandom_range(0, 3));
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen) begin
        rdy = 1'b0;
      end else begin
        case (mode)
          RxOpen:   rdy = 1'b1;
          RxCoin:   rdy = 1'($urandom_range(0, 1));
          RxSparse: rdy = ($urandom_range(0, 3) == 0);
          default:  rdy = (cyc % 8 != 5) && (cyc % 8 != 6);
        endcase
      end
      dout.ready <= rdy;
    end
  end

  initial begin : stimulus
    rst        <= 1'b1;
    din.valid  <= 1'b0;
    din.year   <= '0;
    din.month  <= '0;
    din.day    <= '0;
    din.hour   <= '0;
    din.minute <= '0;
    din.second <= '0;
    dir_rows = '{
      entry(1990,  1,  1,  0,  0,  0, 0),
      entry(1990,  1,  0,  0,  0,  0, 0),          // day zero at the epoch clamps low
      entry(4095, 15, 31, 31, 63, 63, AllOnes),    // every field at its top clamps high
      entry(1990,  1,  1,  0,  0, 59, 59),
      entry(1990,  1,  1,  0,  1,  0, 60),
      entry(1990,  1,  1,  1,  0,  0, 3600),
      entry(1990,  1,  2,  0,  0,  0, 86400),
      entry(1991,  1,  1,  0,  0,  0, 31536000),
      entry(1950,  1,  1,  0,  0,  0, 0),          // years before the epoch add nothing
      entry(2068,  1,  1,  0,  0,  0, AllOnes),
      entry(   0,  0,  0,  0,  0,  0, Predict),
      entry(1990, 13,  1,  0,  0,  0, Predict),
      entry(1990, 15, 31, 23, 59, 59, Predict),
      entry(1992,  2, 29, 12,  0,  0, Predict),
      entry(1992,  3,  1,  0,  0,  0, Predict),
      entry(2000,  3,  1,  0,  0,  0, Predict),
      entry(2100,  3,  1,  0,  0,  0, Predict),
      entry(1990,  2, 31,  0,  0,  0, Predict),    // day past month end rolls over
      entry(1990,  1,  1, 31, 63, 63, Predict),
      entry(1989, 12, 31, 23, 59, 59, Predict),
      entry(2057, 12, 31, 23, 59, 59, Predict),
      entry(2058,  1, 19,  3, 14,  7, Predict),    // last second that fits
      entry(2058,  1, 19,  3, 14,  8, Predict),
      entry(1990, 12,  0,  0,  0,  0, Predict),
      entry(2024,  7, 15,  9, 30, 45, Predict)
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NumDir; i++) send(dir_rows[i]);
    for (int i = 0; i < NumRandom; i++) begin
      send({random_stamp(), 1'b0, epoch_t'(0)});
    end
    din.valid <= 1'b0;
    // let the scoreboard record the last accepted item
    @(posedge clk);
    while (epoch_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("date_time_to_epoch_seconds_top_tb: done, clean");
    end else begin
      $display("date_time_to_epoch_seconds_top_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/dtes_pkg.sv
hdl/dtes_if.sv
hdl/date_time_to_epoch_seconds_top.sv
dv/date_time_to_epoch_seconds_top_tb.sv
